### src/alm_pkg.sv
// Shared types, constants and helpers for the access list match table.
// No dependencies; every module of the block imports this package.
package alm_pkg;

    // Table depth and derived widths
    localparam int ENTRIES = 32;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Field widths and key layout: key = facility * RADIX + card remainder
    localparam int FAC_W  = 8;
    localparam int CARD_W = 20;
    localparam int KEY_W  = 26;
    localparam logic [16:0] RADIX = 17'd100000;

    // Restoring reduction of the card number: 4 quotient bits cover 20 bits
    localparam int RED_STEPS = 4;
    localparam logic [2:0] MUL_STEP = 3'(RED_STEPS);

    typedef enum logic [1:0] {
        MODE_GRANT  = 2'd0,
        MODE_REVOKE = 2'd1,
        MODE_CHECK  = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_KEY,
        S_SCAN,
        S_FINISH
    } state_t;

    // Sequencer to entry store
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             clear;
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
    } store_ctrl_t;

    // Entry store to sequencer
    typedef struct packed {
        logic hit;
        logic empty;
    } store_stat_t;

    // Divisor used in reduction step n: RADIX shifted left by (3 - n)
    function automatic logic [CARD_W-1:0] reduce_div(input logic [2:0] step);
        logic [1:0] sh;
        sh = 2'(3'(RED_STEPS - 1) - step);
        return CARD_W'(RADIX) << sh;
    endfunction

endpackage

### src/alm_key.sv
// Key builder: reduces the card number mod 100000 by restoring subtraction,
// then forms facility * 100000 + remainder. Depends on alm_pkg.
module alm_key (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  logic [alm_pkg::FAC_W-1:0]  facility,
    input  logic [alm_pkg::CARD_W-1:0] card_number,
    output logic [alm_pkg::KEY_W-1:0]  key,
    output logic                       key_done
);
    import alm_pkg::*;

    logic              active_reg;
    logic [2:0]        step_reg;
    logic              done_reg;
    logic [CARD_W-1:0] rem_reg;
    logic [CARD_W-1:0] rem_next;
    logic [FAC_W-1:0]  fac_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  key_next;
    logic [CARD_W-1:0] divisor;

    // One compare-subtract step of the reduction
    always_comb
    begin
        divisor  = reduce_div(step_reg);
        rem_next = (rem_reg >= divisor) ? rem_reg - divisor : rem_reg;
        key_next = KEY_W'(fac_reg) * KEY_W'(RADIX) + KEY_W'(rem_reg);
    end

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            step_reg   <= 3'd0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (load)
            begin
                active_reg <= 1'b1;
                step_reg   <= 3'd0;
            end
            else if (active_reg)
            begin
                if (step_reg == MUL_STEP)
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 3'd1;
                end
            end
        end
    end

    // Operand and key registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= card_number;
            fac_reg <= facility;
        end
        else if (active_reg)
        begin
            if (step_reg == MUL_STEP)
            begin
                key_reg <= key_next;
            end
            else
            begin
                rem_reg <= rem_next;
            end
        end
    end

    assign key      = key_reg;
    assign key_done = done_reg;

endmodule

### src/alm_store.sv
// Entry store: keys with per-slot valid bits and the shared key comparator.
// Depends on alm_pkg.
module alm_store (
    input  logic                      clk,
    input  logic                      rst_n,
    input  alm_pkg::store_ctrl_t      ctrl,
    input  logic [alm_pkg::KEY_W-1:0] key,
    output alm_pkg::store_stat_t      stat
);
    import alm_pkg::*;

    logic [KEY_W-1:0]   key_mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;

    // Compare the scanned slot against the item's key
    always_comb
    begin
        stat.empty = !valid_reg[ctrl.idx];
        stat.hit   = valid_reg[ctrl.idx] && (key_mem[ctrl.idx] == key);
    end

    // Valid bits: set on insert, drop on revoke hit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctrl.wr_en)
        begin
            valid_reg[ctrl.wr_idx] <= 1'b1;
        end
        else if (ctrl.clear)
        begin
            valid_reg[ctrl.idx] <= 1'b0;
        end
    end

    // Key storage
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            key_mem[ctrl.wr_idx] <= key;
        end
    end

endmodule

### src/access_list_match_table.sv
// Top level of the access list match table: sequencer, key builder, store.
// Depends on alm_pkg, alm_key and alm_store.
//
//  channel   ports                              handshake
//  -------   ---------------------------------  ------------------------------
//  item in   mode, facility, card_number         taken when start & !busy
//  result    success                             valid while done is high
//
// An item runs from acceptance to its done strobe by building the key, then
// scanning one slot per cycle through the single comparator, then inserting
// and reporting in the finishing state.
// Reset leaves every slot empty; the table is usable in the first cycle.
// busy drops in the cycle the result is shown, so a new item may follow at
// once; no new item is taken while busy is high.
// The receiver cannot stall: each result is shown for one cycle only.
module access_list_match_table (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 mode,
    input  logic [alm_pkg::FAC_W-1:0]  facility,
    input  logic [alm_pkg::CARD_W-1:0] card_number,
    output logic                       done,
    output logic                       success
);
    import alm_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    mode_t            mode_reg;
    logic             card_ok_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             hit_reg;
    logic             hit_next;
    logic             free_reg;
    logic             free_next;
    logic [IDX_W-1:0] free_idx_reg;
    logic [IDX_W-1:0] free_idx_next;
    logic             done_reg;
    logic             done_next;
    logic             success_reg;
    logic             success_next;

    logic             accept;
    logic [KEY_W-1:0] key;
    logic             key_done;
    store_ctrl_t      ctrl;
    store_stat_t      stat;

    assign accept = start && (state_reg == S_IDLE);

    alm_key u_key (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept),
        .facility    (facility),
        .card_number (card_number),
        .key         (key),
        .key_done    (key_done)
    );

    alm_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .key   (key),
        .stat  (stat)
    );

    // Next state, scan bookkeeping and store control
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        hit_next      = hit_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        done_next     = 1'b0;
        success_next  = 1'b0;
        ctrl.idx      = idx_reg;
        ctrl.clear    = 1'b0;
        ctrl.wr_en    = 1'b0;
        ctrl.wr_idx   = free_idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_KEY;
                end
            end
            S_KEY:
            begin
                // Wait for the key, then scan from slot zero
                if (key_done)
                begin
                    state_next = S_SCAN;
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    free_next  = 1'b0;
                end
            end
            S_SCAN:
            begin
                // Accumulate hits, note the lowest empty slot, drop on revoke
                if (stat.hit)
                begin
                    hit_next = 1'b1;
                end
                if (stat.empty && !free_reg)
                begin
                    free_next     = 1'b1;
                    free_idx_next = idx_reg;
                end
                ctrl.clear = (mode_reg == MODE_REVOKE) && stat.hit;
                if (idx_reg == IDX_W'(ENTRIES - 1))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_FINISH:
            begin
                // Insert on a grant miss when a slot is free, and report
                state_next = S_IDLE;
                done_next  = 1'b1;
                case (mode_reg)
                    MODE_GRANT:
                    begin
                        ctrl.wr_en   = !hit_reg && free_reg;
                        success_next = hit_reg || free_reg;
                    end
                    MODE_REVOKE:
                    begin
                        success_next = hit_reg;
                    end
                    MODE_CHECK:
                    begin
                        success_next = hit_reg && card_ok_reg;
                    end
                    default:
                    begin
                        success_next = 1'b0;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            done_reg    <= 1'b0;
            success_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            done_reg    <= done_next;
            success_reg <= success_next;
        end
    end

    // Item and scan registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg    <= mode_t'(mode);
            card_ok_reg <= (card_number < CARD_W'(RADIX));
        end
        idx_reg      <= idx_next;
        hit_reg      <= hit_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
    end

    assign busy    = (state_reg != S_IDLE);
    assign done    = done_reg;
    assign success = success_reg;

    // A result strobe only ever follows a finishing cycle
    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_FINISH))
        else $error("result strobe without a finishing cycle");

    // An accepted item makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start work");

    // Success is only reported with a strobe
    a_success_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        success_reg |-> done_reg)
        else $error("success without result strobe");

    // Inserts happen only when finishing a grant
    a_write_grant: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.wr_en |-> (state_reg == S_FINISH) && (mode_reg == MODE_GRANT))
        else $error("store write outside a grant finish");

    // Slots are cleared only while scanning for a revoke
    a_clear_revoke: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clear |-> (state_reg == S_SCAN) && (mode_reg == MODE_REVOKE))
        else $error("store clear outside a revoke scan");

endmodule

### sim/tb_top.sv
// Self-checking bench for access_list_match_table: grant, revoke and check items
// are scored against a behavioral model of the 32-slot card key table.
// Depends on alm_pkg and the access_list_match_table RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import alm_pkg::*;

    localparam int CARD_RADIX   = 100000;
    localparam int POOL_SIZE    = 48;
    localparam int RANDOM_ITEMS = 650;
    localparam int BLOCK_ITEMS  = 50;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 60;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        mode_t             mode;
        logic [FAC_W-1:0]  fac;
        logic [CARD_W-1:0] card;
    } card_item_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic [1:0]        mode = MODE_GRANT;
    logic [FAC_W-1:0]  facility = '0;
    logic [CARD_W-1:0] card_number = '0;
    logic              busy;
    logic              done;
    logic              success;

    // Items waiting to be sent and success bits waiting to come back
    card_item_t pend_q[$];
    bit         success_q[$];

    // Model copy of the key table
    logic [KEY_W-1:0] key_slot[ENTRIES];
    bit               key_valid[ENTRIES];

    // Card pool used to build hitting sequences
    logic [FAC_W-1:0]  pool_fac[POOL_SIZE];
    int unsigned       pool_rem[POOL_SIZE];

    card_item_t cur_item;
    int         gap_left = 0;
    int         n_sent = 0;
    int         fail_cnt = 0;
    int         stall_cnt = 0;

    access_list_match_table i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .facility   (facility),
        .card_number(card_number),
        .done       (done),
        .success    (success)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Apply one item to the model table and return its success bit
    function automatic bit table_apply(card_item_t it);
        int  key;
        bit  hit;
        key = (int'(it.fac) * CARD_RADIX + int'(it.card) % CARD_RADIX) & ((1 << KEY_W) - 1);
        hit = 1'b0;
        case (it.mode)
            MODE_GRANT:
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (key_valid[i] && int'(key_slot[i]) == key)
                        hit = 1'b1;
                for (int i = 0; i < ENTRIES && !hit; i++)
                    if (!key_valid[i])
                    begin
                        key_valid[i] = 1'b1;
                        key_slot[i]  = KEY_W'(key);
                        hit = 1'b1;
                    end
            end
            MODE_REVOKE:
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (key_valid[i] && int'(key_slot[i]) == key)
                    begin
                        key_valid[i] = 1'b0;
                        key_slot[i]  = '0;
                        hit = 1'b1;
                    end
            end
            MODE_CHECK:
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (key_valid[i] && int'(key_slot[i]) / CARD_RADIX == int'(it.fac)
                        && int'(key_slot[i]) % CARD_RADIX == int'(it.card))
                        hit = 1'b1;
            end
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    task automatic push_item(mode_t m, int f, int c);
        card_item_t it;
        it.mode = m;
        it.fac  = FAC_W'(f);
        it.card = CARD_W'(c);
        pend_q.push_back(it);
    endtask

    // Build one random item; pool keys dominate so the table fills and hits
    task automatic push_random(int grant_pct);
        int    r;
        int    p;
        int    f;
        int    c;
        mode_t m;
        r = $urandom_range(99);
        if (r < grant_pct)
            m = MODE_GRANT;
        else if (r < grant_pct + (100 - grant_pct) * 4 / 10)
            m = MODE_REVOKE;
        else if (r < grant_pct + (100 - grant_pct) * 9 / 10)
            m = MODE_CHECK;
        else
            m = MODE_NONE;
        p = $urandom_range(POOL_SIZE - 1);
        f = pool_fac[p];
        c = pool_rem[p];
        if ($urandom_range(99) < 15)
        begin
            f = $urandom_range(255);
            c = $urandom_range((1 << CARD_W) - 1);
        end
        else if (m == MODE_CHECK)
        begin
            r = $urandom_range(99);
            if (r < 15)
                c = c + CARD_RADIX * $urandom_range(1, 9);
            else if (r < 25)
                f = $urandom_range(255);
        end
        else
            c = c + CARD_RADIX * $urandom_range(0, 9);
        push_item(m, f, c);
    endtask

    // Fill the stimulus queue, then wait for the table to drain and report
    initial
    begin
        int gw;
        for (int i = 0; i < ENTRIES; i++)
        begin
            key_valid[i] = 1'b0;
            key_slot[i]  = '0;
        end
        pool_fac[0] = '0;
        pool_rem[0] = 0;
        pool_fac[1] = '1;
        pool_rem[1] = CARD_RADIX - 1;
        for (int i = 2; i < POOL_SIZE; i++)
        begin
            pool_fac[i] = FAC_W'($urandom_range(255));
            pool_rem[i] = $urandom_range(CARD_RADIX - 1);
        end

        // Directed: empty table, extremes, reduction, large card, unused mode
        push_item(MODE_CHECK,  0,   0);
        push_item(MODE_REVOKE, 0,   0);
        push_item(MODE_GRANT,  0,   0);
        push_item(MODE_CHECK,  0,   0);
        push_item(MODE_GRANT,  255, (1 << CARD_W) - 1);
        push_item(MODE_CHECK,  255, ((1 << CARD_W) - 1) % CARD_RADIX);
        push_item(MODE_CHECK,  255, (1 << CARD_W) - 1);
        push_item(MODE_GRANT,  255, ((1 << CARD_W) - 1) % CARD_RADIX + CARD_RADIX);
        push_item(MODE_GRANT,  0,   CARD_RADIX - 1);
        push_item(MODE_CHECK,  0,   CARD_RADIX - 1);
        push_item(MODE_CHECK,  1,   CARD_RADIX - 1);
        push_item(MODE_CHECK,  0,   CARD_RADIX);
        push_item(MODE_NONE,   0,   0);
        push_item(MODE_NONE,   255, (1 << CARD_W) - 1);
        push_item(MODE_CHECK,  0,   0);
        push_item(MODE_REVOKE, 255, ((1 << CARD_W) - 1) % CARD_RADIX + 2 * CARD_RADIX);
        push_item(MODE_CHECK,  255, ((1 << CARD_W) - 1) % CARD_RADIX);
        push_item(MODE_REVOKE, 255, ((1 << CARD_W) - 1) % CARD_RADIX);
        push_item(MODE_GRANT,  170, 699050);
        push_item(MODE_CHECK,  170, 699050 % CARD_RADIX);
        push_item(MODE_GRANT,  85,  349525);
        push_item(MODE_CHECK,  85,  349525 % CARD_RADIX);

        // Random: blocks with different grant pressure to fill and drain the table
        for (int b = 0; b < RANDOM_ITEMS / BLOCK_ITEMS; b++)
        begin
            case ($urandom_range(2))
                0: gw = 15;
                1: gw = 45;
                default: gw = 75;
            endcase
            if (b == 0)
                gw = 85;
            for (int i = 0; i < BLOCK_ITEMS; i++)
                push_random(gw);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pend_q.size() != 0 || start || success_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (success_q.size() != 0)
        begin
            $display("ERROR: %0d results never arrived", success_q.size());
            fail_cnt += success_q.size();
        end
        if (fail_cnt == 0)
            $display("access_list_match_table test passed");
        else
            $display("access_list_match_table test failed");
        $finish;
    end

    // Drive items: predict on acceptance, hold while busy, idle at random
    always @(posedge clk)
    begin
        bit taken;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            taken = start && !busy;
            if (taken)
            begin
                success_q.push_back(table_apply(cur_item));
                n_sent++;
                if (!(n_sent >= 250 && n_sent < 400) && $urandom_range(99) < 20)
                    gap_left = $urandom_range(1, 25);
            end
            if (start && !taken)
            begin
                // hold the item until the block takes it
            end
            else if (gap_left > 0)
            begin
                // count idle cycles only once the block is ready again
                if (!busy && !taken)
                    gap_left--;
                start <= 1'b0;
            end
            else if (pend_q.size() != 0)
            begin
                cur_item = pend_q.pop_front();
                start       <= 1'b1;
                mode        <= cur_item.mode;
                facility    <= cur_item.fac;
                card_number <= cur_item.card;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Score each strobed result against the oldest prediction
    always @(posedge clk)
    begin
        bit want;
        if (rst_n && done)
        begin
            if (success_q.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= MAX_REPORTS)
                    $display("ERROR: unexpected result, success=%b", success);
            end
            else
            begin
                want = success_q.pop_front();
                if (success !== want)
                begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS)
                        $display("ERROR: success mismatch: expected %b, got %b", want, success);
                end
            end
        end
    end

    // Stop the run if nothing moves on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cnt <= 0;
            else
                stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_LIMIT)
            begin
                $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
                $display("access_list_match_table test failed");
                $finish;
            end
        end
    end

endmodule

### filelist.f
src/alm_pkg.sv
src/alm_key.sv
src/alm_store.sv
src/access_list_match_table.sv
sim/tb_top.sv
